@@ hdl/iidl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package iidl_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int ERR_W        = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_AT    = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_BACK  = 3'd2,
        CMD_DEL_AT    = 3'd3,
        CMD_DEL_FRONT = 3'd4,
        CMD_DEL_BACK  = 3'd5,
        CMD_READ      = 3'd6
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] value;
    } shift_ctrl_t;

    typedef struct packed {
        err_t err;
        logic rd_hit;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/iidl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iidl_cell
    import iidl_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 5
)
(
    input  wire                     clk,
    input  wire                     en,
    input  shift_ctrl_t             ctrl,
    input  wire  [COUNT_W-1:0]      at,
    input  wire  [DATA_W-1:0]       left_data,
    input  wire  [DATA_W-1:0]       right_data,
    output logic [DATA_W-1:0]       data
);

    localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (IDX_C == at)
                begin
                    data_next = ctrl.value;
                end
                else if (IDX_C > at)
                begin
                    data_next = left_data;
                end
            end
            OP_DELETE:
            begin
                if (IDX_C >= at)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ hdl/iidl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iidl_ctrl
    import iidl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int COUNT_W  = $clog2(CAPACITY + 1)
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire  [CMD_W-1:0]        cmd,
    input  wire  [COUNT_W-1:0]      position,
    input  wire  [DATA_W-1:0]       value,
    output shift_ctrl_t             ctrl,
    output logic [COUNT_W-1:0]      at,
    output status_t                 status,
    output logic [COUNT_W-1:0]      length_next
);

    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);
    localparam logic [COUNT_W-1:0] ONE_C = COUNT_W'(1);

    logic [COUNT_W-1:0] length_reg;
    cmd_t               cmd_e;

    assign cmd_e = cmd_t'(cmd);

    always_comb
    begin
        ctrl.op       = OP_HOLD;
        ctrl.value    = value;
        at            = '0;
        status.err    = ERR_OK;
        status.rd_hit = 1'b0;
        length_next   = length_reg;
        unique case (cmd_e) inside
            CMD_INS_AT, CMD_INS_FRONT, CMD_INS_BACK:
            begin
                if (length_reg == CAP_C)
                begin
                    status.err = ERR_FULL;
                end
                else if (cmd_e == CMD_INS_AT && position > length_reg)
                begin
                    status.err = ERR_RANGE;
                end
                else
                begin
                    ctrl.op     = OP_INSERT;
                    length_next = length_reg + ONE_C;
                    if (cmd_e == CMD_INS_AT)
                    begin
                        at = position;
                    end
                    else if (cmd_e == CMD_INS_BACK)
                    begin
                        at = length_reg;
                    end
                end
            end
            CMD_DEL_AT, CMD_DEL_FRONT, CMD_DEL_BACK:
            begin
                if (length_reg == '0)
                begin
                    status.err = ERR_EMPTY;
                end
                else if (cmd_e == CMD_DEL_AT && position >= length_reg)
                begin
                    status.err = ERR_RANGE;
                end
                else
                begin
                    ctrl.op     = OP_DELETE;
                    length_next = length_reg - ONE_C;
                    if (cmd_e == CMD_DEL_AT)
                    begin
                        at = position;
                    end
                    else if (cmd_e == CMD_DEL_BACK)
                    begin
                        at = length_reg - ONE_C;
                    end
                end
            end
            CMD_READ:
            begin
                if (position >= length_reg)
                begin
                    status.err = ERR_RANGE;
                end
                else
                begin
                    status.rd_hit = 1'b1;
                end
            end
            default:
            begin
                status.err = ERR_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (en)
        begin
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/indexed_insert_delete_list.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Response is valid the cycle after acceptance; cells from the index on update too.
// Throughput: 1 command per cycle unless a response waits with rsp_ready low.
// A waiting response does not block the next command while rsp_ready is high.
// Reset: asynchronous, active low; clears the stored length and response valid.
// Entry storage is not reset; entries beyond the count are never returned.

module indexed_insert_delete_list
    import iidl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int COUNT_W  = $clog2(CAPACITY + 1)
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cmd_valid,
    output logic                    cmd_ready,
    input  wire  [CMD_W-1:0]        cmd,
    input  wire  [COUNT_W-1:0]      position,
    input  wire  [DATA_W-1:0]       value,
    output logic                    rsp_valid,
    input  wire                     rsp_ready,
    output logic [DATA_W-1:0]       read_value,
    output logic [COUNT_W-1:0]      entry_count,
    output logic [ERR_W-1:0]        error_code
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                accept;
    shift_ctrl_t         ctrl;
    logic [COUNT_W-1:0]  at;
    status_t             status;
    logic [COUNT_W-1:0]  length_next;
    logic [DATA_W-1:0]   cell_data [CAPACITY];

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [DATA_W-1:0]   read_value_reg;
    logic [DATA_W-1:0]   read_value_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [ERR_W-1:0]    error_code_reg;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    iidl_ctrl #(
        .CAPACITY (CAPACITY),
        .COUNT_W  (COUNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (accept),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .ctrl        (ctrl),
        .at          (at),
        .status      (status),
        .length_next (length_next)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        iidl_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk        (clk),
            .en         (accept),
            .ctrl       (ctrl),
            .at         (at),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        read_value_next = '0;
        if (status.rd_hit)
        begin
            read_value_next = cell_data[position[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= read_value_next;
            entry_count_reg <= length_next;
            error_code_reg  <= status.err;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign error_code  = error_code_reg;

endmodule

`default_nettype wire
